// ===== hdl/apq_pkg.sv =====
// Shared constants and types of the aging priority queue.
package apq_pkg;

   localparam int DEPTH   = 16;
   localparam int ID_W    = 16;
   localparam int PRIO_W  = 8;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   localparam logic [31:0] MAX_PRIO    = 32'd255;
   localparam logic [31:0] MAX_ITEM_ID = 32'd65535;

   typedef enum logic {
      OP_INSERT   = 1'b0,
      OP_RETRIEVE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_RETRIEVED = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // One slot of the sorted row.
   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // What a cell hands to its right neighbor.
   typedef struct packed {
      entry_type entry;
      logic      disp;   // this slot moves right on the current insert
   } link_type;

   // Operation broadcast to every cell.
   typedef struct packed {
      logic              ins;
      logic              ret;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } cmd_type;

   // One result as it waits in the output buffer.
   typedef struct packed {
      logic [ID_W-1:0]    out_id;
      status_type         status;
      logic [COUNT_W-1:0] fill_count;
   } rsp_type;

endpackage

// ===== hdl/apq_req_if.sv =====
// Request channel: one queue operation per transfer.
interface apq_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [apq_pkg::ID_W-1:0]   item_id;
   logic [apq_pkg::PRIO_W-1:0] item_priority;

   modport source (output valid, opcode, item_id, item_priority, input ready);
   modport sink   (input valid, opcode, item_id, item_priority, output ready);
endinterface

// ===== hdl/apq_rsp_if.sv =====
// Response channel: one result per transfer.
interface apq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [apq_pkg::ID_W-1:0]    out_id;
   logic [1:0]                  status;
   logic [apq_pkg::COUNT_W-1:0] fill_count;

   modport source (output valid, out_id, status, fill_count, input ready);
   modport sink   (input valid, out_id, status, fill_count, output ready);
endinterface

// ===== hdl/apq_cell.sv =====
// One slot of the sorted row: shifts right on insert, left with aging on retrieve.
module apq_cell (
   input  logic               clock,
   input  logic               reset,
   input  apq_pkg::cmd_type   cmd,
   input  apq_pkg::link_type  prev_link,
   input  apq_pkg::entry_type next_entry,
   output apq_pkg::link_type  link
);

   apq_pkg::entry_type entry_ff;
   apq_pkg::entry_type entry_in;
   logic               disp;

   assign disp = entry_ff.valid && (entry_ff.prio > cmd.prio);
   assign link = '{entry: entry_ff, disp: disp};

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (!(entry_ff.valid && !disp)) begin
            if (prev_link.disp) begin
               entry_in = prev_link.entry;
            end else if (entry_ff.valid || prev_link.entry.valid) begin
               entry_in = '{valid: 1'b1, id: cmd.id, prio: cmd.prio};
            end
         end
      end else if (cmd.ret) begin
         entry_in = next_entry;
         if (next_entry.prio > apq_pkg::PRIO_W'(1)) begin
            entry_in.prio = next_entry.prio - apq_pkg::PRIO_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.id   <= entry_in.id;
      entry_ff.prio <= entry_in.prio;
   end

endmodule

// ===== hdl/apq_out_buf.sv =====
// Two-entry output buffer (main register plus skid) in front of the response channel.
module apq_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  apq_pkg::rsp_type in_data,
   apq_rsp_if.source        rsp_if
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   apq_pkg::rsp_type main_data_ff, main_data_in;
   apq_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             pop;

   assign in_ready = !skid_valid_ff;
   assign pop      = main_valid_ff && rsp_if.ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (in_valid && in_ready) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (pop) begin
         main_valid_in = skid_valid_ff;
         main_data_in  = skid_data_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_if.valid      = main_valid_ff;
   assign rsp_if.out_id     = main_data_ff.out_id;
   assign rsp_if.status     = main_data_ff.status;
   assign rsp_if.fill_count = main_data_ff.fill_count;

endmodule

// ===== hdl/aging_priority_queue_unit.sv =====
// Top level of the aging priority queue: cell row, fill counter and output buffer.
//
// Usage:
//   req_if carries one operation per transfer: opcode insert (item_id,
//   item_priority) or retrieve. rsp_if returns exactly one result per
//   operation, in order: out_id, status and the fill count after the op.
//   The queue is a row of DEPTH cells kept sorted by priority, head in cell 0.
//   An insert is broadcast to all cells; each keeps, shifts right or loads
//   the new entry in the same cycle. A retrieve shifts the row left and ages
//   every moved priority by one, floored at 1.
// Output: each result is registered in the output buffer (main or skid register).
// Throughput: one operation per cycle while req_if.ready is high; the cell row
//   and the fill counter handle each operation as it is accepted.
// Stall: a two-entry output buffer holds results; req_if.ready drops only
//   when both entries are occupied, so one request is still taken while a
//   result waits.
// Reset: synchronous, active high; clears the fill count, every cell's valid
//   bit and the output buffer. No clearing pass is needed.
module aging_priority_queue_unit (
   input  logic      clock,
   input  logic      reset,
   apq_req_if.sink   req_if,
   apq_rsp_if.source rsp_if
);

   localparam int DEPTH   = apq_pkg::DEPTH;
   localparam int COUNT_W = apq_pkg::COUNT_W;
   localparam int ID_W    = apq_pkg::ID_W;
   localparam int PRIO_W  = apq_pkg::PRIO_W;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               req_fire;
   logic               is_insert;
   logic               full;
   logic               empty;
   logic               buf_ready;
   logic [PRIO_W-1:0]  prio_sat;
   logic [ID_W-1:0]    id_sat;
   apq_pkg::cmd_type   cmd;
   apq_pkg::rsp_type   rsp_data;

   apq_pkg::link_type  links [DEPTH];

   assign req_fire  = req_if.valid && buf_ready;
   assign is_insert = (req_if.opcode == apq_pkg::OP_INSERT);
   assign full      = (count_ff == COUNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign req_if.ready = buf_ready;

   // Saturate the inserted fields into their legal ranges.
   always_comb begin
      prio_sat = req_if.item_priority;
      if (prio_sat == '0) begin
         prio_sat = PRIO_W'(1);
      end else if (32'(prio_sat) > apq_pkg::MAX_PRIO) begin
         prio_sat = apq_pkg::MAX_PRIO[PRIO_W-1:0];
      end
      id_sat = req_if.item_id;
      if (32'(id_sat) > apq_pkg::MAX_ITEM_ID) begin
         id_sat = apq_pkg::MAX_ITEM_ID[ID_W-1:0];
      end
   end

   // Broadcast command; refused ops leave the row untouched.
   assign cmd.ins  = req_fire && is_insert && !full;
   assign cmd.ret  = req_fire && !is_insert && !empty;
   assign cmd.id   = id_sat;
   assign cmd.prio = prio_sat;

   // Cell row. Cell 0 sees a valid, never-displaced left neighbor; the last
   // cell pulls an empty slot on retrieve.
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      apq_pkg::link_type  prev_link;
      apq_pkg::entry_type next_entry;

      if (k == 0) begin : g_head
         assign prev_link = '{entry: '{valid: 1'b1, id: '0, prio: '0}, disp: 1'b0};
      end else begin : g_body
         assign prev_link = links[k-1];
      end

      if (k == DEPTH - 1) begin : g_tail
         assign next_entry = '{valid: 1'b0, id: '0, prio: '0};
      end else begin : g_mid
         assign next_entry = links[k+1].entry;
      end

      apq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_link  (prev_link),
         .next_entry (next_entry),
         .link       (links[k])
      );
   end

   // Fill counter and result formation.
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.ret) begin
         count_in = count_ff - COUNT_W'(1);
      end

      rsp_data.out_id = '0;
      if (is_insert) begin
         rsp_data.status = full ? apq_pkg::ST_FULL : apq_pkg::ST_INSERTED;
      end else if (empty) begin
         rsp_data.status = apq_pkg::ST_EMPTY;
      end else begin
         rsp_data.status = apq_pkg::ST_RETRIEVED;
         rsp_data.out_id = links[0].entry.id;
      end
      rsp_data.fill_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   apq_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_ready (buf_ready),
      .in_data  (rsp_data),
      .rsp_if   (rsp_if)
   );

   // Count never exceeds the row length.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("fill count beyond depth");

   // Head cell holds an entry exactly when the queue is not empty.
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      links[0].entry.valid == !empty)
      else $error("head valid out of step with count");

   // Tail cell holds an entry exactly when the queue is full.
   a_tail_valid: assert property (@(posedge clock) disable iff (reset)
      links[DEPTH-1].entry.valid == full)
      else $error("tail valid out of step with count");

   // An accepted insert into a non-full queue grows the count by one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("insert did not grow the queue");

   // A refused operation leaves the count alone.
   a_refused_hold: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !cmd.ins && !cmd.ret) |=> $stable(count_ff))
      else $error("refused operation changed the count");

endmodule
